@@ hw/rtl/mips_integer_execute_unit_assert.svh @@
// Assertion macros for the MIPS integer execute unit.
// Depends on nothing; included by the top level.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
// implication checked on every edge outside reset
`define MIEU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MIEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/mieu_pkg.sv @@
// Package for the MIPS integer execute unit: status codes, opcodes, constants.
// Depends on nothing.
package mieu_pkg;
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OVF     = 3'd1;
    localparam logic [2:0] ST_TRAP    = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_SYSCALL = 3'd4;

    localparam logic [31:0] PC_RESET = 32'h0040_0000;
    localparam logic [31:0] GP_RESET = 32'h0050_0000;
    localparam logic [31:0] SP_RESET = 32'h00A0_0000;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;

    // controller to datapath
    typedef struct packed {
        logic exec;       // run an instruction other than mul or nonzero div, write result
        logic div_start;  // load divider
        logic div_step;   // one restoring step
        logic div_done;   // write HI/LO and result
        logic mul_fin;    // write HI/LO from product register
    } mieu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic is_mul;
        logic div_zero;
    } mieu_stat_t;
endpackage

@@ hw/rtl/mips_integer_execute_unit.sv @@
// MIPS integer execute unit, top level: joins controller and datapath.
// Depends on mieu_pkg, mieu_ctrl, mieu_dp and the assertion macro header.
//
// Executes one MIPS32 instruction word per transaction at the internal PC
// (reset 0x00400000) and returns one result transaction holding status,
// register write and next PC. No delay slots. Most instructions write the
// result register at accept; for mult/multu the product is registered at
// accept and the result written from it in S_MUL. div/divu with a nonzero
// divisor run the one-bit-per-cycle restoring divider through S_DIV and
// S_FIN; a zero divisor is handled at accept. A word is accepted once the
// previous one has finished and the result register is free or draining.
module mips_integer_execute_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instruction_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [2:0] status, [3] reg_written,
                                   // [8:4] dest_index, [40:9] dest_value,
                                   // [72:41] next_pc, [79:73] zero
);
    import mieu_pkg::*;
    `include "mips_integer_execute_unit_assert.svh"

    mieu_cmd_t  cmd;
    mieu_stat_t stat;
    logic [79:0] dp_data;

    mieu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mieu_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_accept (s_tvalid && s_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tdata  (dp_data)
    );

    // result register drives the output channel directly
    assign m_tdata = dp_data;

    `MIEU_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.exec, cmd.mul_fin, cmd.div_done}))
    `MIEU_ASSERT_NEXT(a_exec_valid, cmd.exec || cmd.mul_fin || cmd.div_done, m_tvalid)
    `MIEU_ASSERT_IMPL(a_busy_noacc, cmd.div_step, !s_tready)
endmodule

@@ hw/rtl/mieu_ctrl.sv @@
// Controller for the MIPS integer execute unit.
// Depends on mieu_pkg.
module mieu_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mieu_pkg::mieu_stat_t  stat,
    output mieu_pkg::mieu_cmd_t   cmd
);
    import mieu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       out_free;

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign m_tvalid = ov_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !m_tready;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && out_free) begin
                    if (stat.is_mul) begin
                        cmd.exec   = 1'b0;
                        state_next = S_MUL;
                    end else if (stat.is_div && !stat.div_zero) begin
                        cmd.div_start = 1'b1;
                        cnt_next      = 5'd0;
                        state_next    = S_DIV;
                    end else begin
                        cmd.exec = 1'b1;
                        ov_next  = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (out_free) begin
                    cmd.mul_fin = 1'b1;
                    ov_next     = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.div_done = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

@@ hw/rtl/mieu_dp.sv @@
// Datapath for the MIPS integer execute unit: register file, HI/LO, PC,
// ALU, multiplier register and a restoring divider. Depends on mieu_pkg.
module mieu_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          s_tdata,
    input  logic                 s_accept,
    input  mieu_pkg::mieu_cmd_t  cmd,
    output mieu_pkg::mieu_stat_t stat,
    output logic [79:0]          m_tdata
);
    import mieu_pkg::*;

    logic [31:0] rf_reg [32];
    logic [31:0] hi_reg, lo_reg, pc_reg;
    logic [63:0] prod_reg;
    logic [31:0] q_reg, r_reg, d_reg;
    logic        qneg_reg, rneg_reg;
    logic [79:0] out_reg;

    logic [31:0] w;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh, sv;
    logic [31:0] a, b, zimm, simm, pc4, bt, s, npc, dv;
    logic [4:0]  di;
    logic [2:0]  st;
    logic        wr, ovf;
    logic signed [32:0] ax, bx;
    logic signed [65:0] pr;
    logic [32:0] rsub;
    logic [31:0] rshift;

    // decode fields of the word being accepted
    assign w  = s_tdata;
    assign op = w[31:26];
    assign rs = w[25:21];
    assign rt = w[20:16];
    assign rd = w[15:11];
    assign sh = w[10:6];
    assign fn = w[5:0];
    assign a  = rf_reg[rs];
    assign b  = rf_reg[rt];
    assign sv = a[4:0];
    assign zimm = {16'h0, w[15:0]};
    assign simm = {{16{w[15]}}, w[15:0]};
    assign pc4  = pc_reg + 32'd4;
    assign bt   = pc4 + {simm[29:0], 2'b00};

    assign stat.is_mul = (op == OP_SPECIAL) && (fn == FN_MULT || fn == FN_MULTU);
    assign stat.is_div = (op == OP_SPECIAL) && (fn == FN_DIV || fn == FN_DIVU);
    assign stat.div_zero = (b == 32'd0);

    function automatic logic lts(input logic [31:0] x, input logic [31:0] y);
        return $signed(x) < $signed(y);
    endfunction

    always_comb begin
        npc = pc4;
        st  = ST_OK;
        wr  = 1'b0;
        di  = 5'd0;
        dv  = 32'd0;
        s   = 32'd0;
        ovf = 1'b0;
        if (op == OP_SPECIAL) begin
            di = rd;
            case (fn)
                6'h00: begin
                    if (w == 32'd0) st = ST_SYSCALL;
                    else begin wr = 1'b1; dv = b << sh; end
                end
                6'h02: begin wr = 1'b1; dv = b >> sh; end
                6'h03: begin wr = 1'b1; dv = 32'($signed(b) >>> sh); end
                6'h04: begin wr = 1'b1; dv = b << sv; end
                6'h06: begin wr = 1'b1; dv = b >> sv; end
                6'h07: begin wr = 1'b1; dv = 32'($signed(b) >>> sv); end
                6'h08: npc = a;
                6'h09: begin npc = a; wr = 1'b1; dv = pc4; end
                6'h10: begin wr = 1'b1; dv = hi_reg; end
                6'h12: begin wr = 1'b1; dv = lo_reg; end
                6'h18, 6'h19, 6'h1A, 6'h1B: ;
                6'h20: begin
                    s   = a + b;
                    ovf = (~(a[31] ^ b[31])) & (a[31] ^ s[31]);
                    if (ovf) st = ST_OVF;
                    else begin wr = 1'b1; dv = s; end
                end
                6'h21: begin wr = 1'b1; dv = a + b; end
                6'h22, 6'h23: begin wr = 1'b1; dv = a - b; end
                6'h24: begin wr = 1'b1; dv = a & b; end
                6'h25: begin wr = 1'b1; dv = a | b; end
                6'h26: begin wr = 1'b1; dv = a ^ b; end
                6'h27: begin wr = 1'b1; dv = ~(a | b); end
                6'h2A: begin wr = 1'b1; dv = {31'd0, lts(a, b)}; end
                6'h2B: begin wr = 1'b1; dv = {31'd0, a < b}; end
                6'h30: if (!lts(a, b)) st = ST_TRAP;
                6'h31: if (a >= b) st = ST_TRAP;
                6'h32: if (lts(a, b)) st = ST_TRAP;
                6'h33: if (a < b) st = ST_TRAP;
                6'h34: if (a == b) st = ST_TRAP;
                6'h36: if (a != b) st = ST_TRAP;
                default: st = ST_UNKNOWN;
            endcase
        end else if (op == OP_REGIMM) begin
            di = 5'd31;
            case (rt)
                5'h00: if (a[31]) npc = bt;
                5'h01: if (!a[31]) npc = bt;
                5'h10: begin if (a[31]) npc = bt; wr = 1'b1; dv = pc4; end
                5'h11: begin if (!a[31]) npc = bt; wr = 1'b1; dv = pc4; end
                5'h08: if (!lts(a, simm)) st = ST_TRAP;
                5'h09: if (a >= simm) st = ST_TRAP;
                5'h0A: if (lts(a, simm)) st = ST_TRAP;
                5'h0B: if (a < simm) st = ST_TRAP;
                5'h0C: if (a == simm) st = ST_TRAP;
                5'h0E: if (a != simm) st = ST_TRAP;
                default: st = ST_UNKNOWN;
            endcase
        end else begin
            di = rt;
            case (op)
                6'h02: npc = {pc4[31:28], w[25:0], 2'b00};
                6'h03: begin
                    npc = {pc4[31:28], w[25:0], 2'b00};
                    wr = 1'b1; di = 5'd31; dv = pc4;
                end
                6'h04: if (a == b) npc = bt;
                6'h05: if (a != b) npc = bt;
                6'h06: if (a[31] || a == 32'd0) npc = bt;
                6'h07: if (!a[31] && a != 32'd0) npc = bt;
                6'h08: begin
                    s   = a + simm;
                    ovf = (~(a[31] ^ simm[31])) & (a[31] ^ s[31]);
                    if (ovf) st = ST_OVF;
                    else begin wr = 1'b1; dv = s; end
                end
                6'h09: begin wr = 1'b1; dv = a + simm; end
                6'h0A: begin wr = 1'b1; dv = {31'd0, lts(a, simm)}; end
                6'h0B: begin wr = 1'b1; dv = {31'd0, a < simm}; end
                6'h0C: begin wr = 1'b1; dv = a & zimm; end
                6'h0D: begin wr = 1'b1; dv = a | zimm; end
                6'h0E: begin wr = 1'b1; dv = a ^ zimm; end
                6'h0F: begin wr = 1'b1; dv = {w[15:0], 16'h0}; end
                default: st = ST_UNKNOWN;
            endcase
        end
        if (!wr || di == 5'd0) begin
            wr = 1'b0; di = 5'd0; dv = 32'd0;
        end
    end

    // one 33x33 signed multiply covers mult and multu
    assign ax = (fn == FN_MULT) ? {a[31], a} : {1'b0, a};
    assign bx = (fn == FN_MULT) ? {b[31], b} : {1'b0, b};
    assign pr = ax * bx;

    // restoring division step on magnitudes
    assign rshift = {r_reg[30:0], q_reg[31]};
    assign rsub   = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            prod_reg <= pr[63:0];
        end
        if (cmd.div_start) begin
            qneg_reg <= (fn == FN_DIV) && (a[31] ^ b[31]);
            rneg_reg <= (fn == FN_DIV) && a[31];
            q_reg    <= ((fn == FN_DIV) && a[31]) ? 32'd0 - a : a;
            d_reg    <= ((fn == FN_DIV) && b[31]) ? 32'd0 - b : b;
            r_reg    <= 32'd0;
        end else if (cmd.div_step) begin
            if (!rsub[32]) begin
                r_reg <= rsub[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= rshift;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
        if (cmd.exec || cmd.mul_fin || cmd.div_done) begin
            if (cmd.exec) out_reg <= {7'd0, npc, dv, di, wr, st};
            else out_reg <= {7'd0, pc4, 32'd0, 5'd0, 1'b0, ST_OK};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) begin
                if (i == 28) rf_reg[i] <= GP_RESET;
                else if (i == 29 || i == 30) rf_reg[i] <= SP_RESET;
                else rf_reg[i] <= 32'd0;
            end
            hi_reg <= 32'd0;
            lo_reg <= 32'd0;
            pc_reg <= PC_RESET;
        end else begin
            if (cmd.exec) begin
                if (wr) rf_reg[di] <= dv;
                pc_reg <= npc;
                if (stat.is_div) begin
                    lo_reg <= 32'hFFFF_FFFF;
                    hi_reg <= a;
                end
            end
            if (cmd.mul_fin) begin
                hi_reg <= prod_reg[63:32];
                lo_reg <= prod_reg[31:0];
                pc_reg <= pc_reg + 32'd4;
            end
            if (cmd.div_done) begin
                lo_reg <= qneg_reg ? 32'd0 - q_reg : q_reg;
                hi_reg <= rneg_reg ? 32'd0 - r_reg : r_reg;
                pc_reg <= pc_reg + 32'd4;
            end
        end
    end

    assign m_tdata = out_reg;
endmodule
